>>> design/uvss_pkg.sv
// ----------------------------------------------------------------------------
// uvss_pkg
// Shared types and constants for the periodic UV sterilize scheduler.
// ----------------------------------------------------------------------------
package uvss_pkg;

    localparam int TPM_W   = 10;
    localparam int HOURS_W = 4;
    localparam int MIN_W   = 8;
    localparam int DEB_W   = 8;
    localparam int CFG_W   = 10;
    localparam int ADDR_W  = 2;

    localparam logic [ADDR_W-1:0] REG_TICKS_PER_MINUTE = 2'd0;
    localparam logic [ADDR_W-1:0] REG_STANDBY_HOURS    = 2'd1;
    localparam logic [ADDR_W-1:0] REG_RUN_MINUTES      = 2'd2;
    localparam logic [ADDR_W-1:0] REG_COVER_DEBOUNCE   = 2'd3;

    localparam logic [TPM_W-1:0]   TICKS_PER_MINUTE_RST = 10'd600;
    localparam logic [HOURS_W-1:0] STANDBY_HOURS_RST    = 4'd6;
    localparam logic [MIN_W-1:0]   RUN_MINUTES_RST      = 8'd120;
    localparam logic [DEB_W-1:0]   COVER_DEBOUNCE_RST   = 8'd10;

    localparam logic [MIN_W:0] MINUTES_PER_HOUR = 9'd60;

    typedef struct packed {
        logic [TPM_W-1:0]   ticks_per_minute;
        logic [HOURS_W-1:0] standby_hours;
        logic [MIN_W-1:0]   run_minutes;
        logic [DEB_W-1:0]   cover_debounce_count;
    } cfg_t;

endpackage

>>> design/uvss_debounce.sv
// ----------------------------------------------------------------------------
// uvss_debounce
// Saturating reed switch debouncer producing the cover state.
// ----------------------------------------------------------------------------
module uvss_debounce
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample,
    input  logic                    level,
    input  logic [uvss_pkg::DEB_W-1:0] limit,
    output logic                    cover_state_next
);
    import uvss_pkg::*;

    logic [DEB_W-1:0] closed_cnt_reg;
    logic [DEB_W-1:0] closed_cnt_next;
    logic [DEB_W-1:0] open_cnt_reg;
    logic [DEB_W-1:0] open_cnt_next;
    logic             cover_reg;
    logic [DEB_W:0]   cnt_inc;

    always_comb
    begin
        closed_cnt_next = closed_cnt_reg;
        open_cnt_next   = open_cnt_reg;
        cover_state_next = cover_reg;
        cnt_inc         = '0;
        if (sample)
        begin
            if (!level)
            begin
                open_cnt_next = '0;
                cnt_inc = {1'b0, closed_cnt_reg} + {{DEB_W{1'b0}}, 1'b1};
                closed_cnt_next = (cnt_inc >= {1'b0, limit}) ? limit : cnt_inc[DEB_W-1:0];
                if (closed_cnt_next >= limit)
                begin
                    cover_state_next = 1'b1;
                end
            end
            else
            begin
                closed_cnt_next = '0;
                cnt_inc = {1'b0, open_cnt_reg} + {{DEB_W{1'b0}}, 1'b1};
                open_cnt_next = (cnt_inc >= {1'b0, limit}) ? limit : cnt_inc[DEB_W-1:0];
                if (open_cnt_next >= limit)
                begin
                    cover_state_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_cnt_reg <= '0;
            open_cnt_reg   <= '0;
            cover_reg      <= 1'b0;
        end
        else
        begin
            closed_cnt_reg <= closed_cnt_next;
            open_cnt_reg   <= open_cnt_next;
            cover_reg      <= cover_state_next;
        end
    end

endmodule

>>> design/uvss_schedule.sv
// ----------------------------------------------------------------------------
// uvss_schedule
// Standby and run timers of the lamp schedule, one step per tick.
// ----------------------------------------------------------------------------
module uvss_schedule
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic           enable,
    input  logic           blk,
    input  uvss_pkg::cfg_t cfg,
    output logic           req,
    output logic           run_phase_next
);
    import uvss_pkg::*;

    logic               run_phase_reg;
    logic               run_active_reg;
    logic               run_active_next;
    logic [TPM_W-1:0]   sub_reg;
    logic [TPM_W-1:0]   sub_next;
    logic [MIN_W-1:0]   min_reg;
    logic [MIN_W-1:0]   min_next;
    logic [HOURS_W-1:0] hour_reg;
    logic [HOURS_W-1:0] hour_next;
    logic [TPM_W:0]     sub_inc;
    logic [MIN_W:0]     min_inc;
    logic [HOURS_W:0]   hour_inc;
    logic               sub_wrap;

    // minute step shared by standby and run
    always_comb
    begin
        sub_inc  = {1'b0, sub_reg} + {{TPM_W{1'b0}}, 1'b1};
        sub_wrap = (sub_inc >= {1'b0, cfg.ticks_per_minute});
        min_inc  = {1'b0, min_reg} + {{MIN_W{1'b0}}, sub_wrap};
    end

    always_comb
    begin
        sub_next        = sub_reg;
        min_next        = min_reg;
        hour_next       = hour_reg;
        run_phase_next  = run_phase_reg;
        run_active_next = run_active_reg;
        req             = 1'b0;
        hour_inc        = {1'b0, hour_reg};
        if (step)
        begin
            if (!enable)
            begin
                sub_next        = '0;
                min_next        = '0;
                hour_next       = '0;
                run_phase_next  = 1'b0;
                run_active_next = 1'b0;
            end
            else if (!run_phase_reg)
            begin
                sub_next = sub_wrap ? '0 : sub_inc[TPM_W-1:0];
                if (min_inc >= MINUTES_PER_HOUR)
                begin
                    min_next = '0;
                    hour_inc = {1'b0, hour_reg} + {{HOURS_W{1'b0}}, 1'b1};
                end
                else
                begin
                    min_next = min_inc[MIN_W-1:0];
                end
                if (hour_inc >= {1'b0, cfg.standby_hours})
                begin
                    sub_next        = '0;
                    min_next        = '0;
                    hour_next       = '0;
                    run_phase_next  = 1'b1;
                    run_active_next = 1'b1;
                end
                else
                begin
                    hour_next = hour_inc[HOURS_W-1:0];
                end
            end
            else if (run_active_reg)
            begin
                if (!blk)
                begin
                    req = 1'b1;
                    if (min_inc >= {1'b0, cfg.run_minutes})
                    begin
                        sub_next        = '0;
                        min_next        = '0;
                        hour_next       = '0;
                        run_active_next = 1'b0;
                    end
                    else
                    begin
                        sub_next = sub_wrap ? '0 : sub_inc[TPM_W-1:0];
                        min_next = min_inc[MIN_W-1:0];
                    end
                end
            end
            else
            begin
                run_phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_phase_reg  <= 1'b0;
            run_active_reg <= 1'b0;
            sub_reg        <= '0;
            min_reg        <= '0;
            hour_reg       <= '0;
        end
        else
        begin
            run_phase_reg  <= run_phase_next;
            run_active_reg <= run_active_next;
            sub_reg        <= sub_next;
            min_reg        <= min_next;
            hour_reg       <= hour_next;
        end
    end

endmodule

>>> design/periodic_uv_sterilize_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_uv_sterilize_scheduler
// Duty-cycle UV lamp scheduler with cover debounce and lamp blocking.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata, one per clock at most.
//   Each item carries the tick, reed sample, enable, extraction, motor and
//   self-test flags. Every item yields one result item on m_tvalid/m_tready/
//   m_tdata with the lamp level, run phase, debounced cover and block flag.
//   An item is held in the input register and the whole update is done from
//   there into the result register, which drives m_tvalid; throughput one
//   item per clock while the receiver does not stall.
//   Configuration registers are written through cfg_we/cfg_addr/cfg_wdata
//   while no item is in flight.
//   Reset clears all timers, the debouncer, the block latches and the lamp,
//   and loads the register defaults.
//   When the receiver stalls, the result is held and the input register
//   keeps one more item; s_tready drops only while both are full.
// ----------------------------------------------------------------------------
module periodic_uv_sterilize_scheduler
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [0] timer_tick, [1] reed_strobe, [2] reed_level, [3] feature_enable,
    // [4] extract_active, [5] motor_moving, [6] self_test, [7] zero
    input  logic [7:0]                  s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] lamp_on, [1] in_run_phase, [2] cover_closed, [3] blocked, [7:4] zero
    output logic [7:0]                  m_tdata,
    input  logic                        cfg_we,
    input  logic [uvss_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [uvss_pkg::CFG_W-1:0]  cfg_wdata
);
    import uvss_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [6:0] in_data_reg;
    logic       out_valid_reg;
    logic [3:0] out_data_reg;
    logic       adv;
    logic       active;
    logic       tick_step;
    logic       cover_block_reg;
    logic       cover_block_next;
    logic       extract_block_reg;
    logic       extract_block_next;
    logic       lamp_reg;
    logic       lamp_next;
    logic       cover_next;
    logic       req;
    logic       run_phase_next;

    assign adv       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || adv;
    assign active    = adv && !in_data_reg[6];
    assign tick_step = active && in_data_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_minute     <= TICKS_PER_MINUTE_RST;
            cfg_reg.standby_hours        <= STANDBY_HOURS_RST;
            cfg_reg.run_minutes          <= RUN_MINUTES_RST;
            cfg_reg.cover_debounce_count <= COVER_DEBOUNCE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TICKS_PER_MINUTE: cfg_reg.ticks_per_minute <= cfg_wdata[TPM_W-1:0];
                REG_STANDBY_HOURS:    cfg_reg.standby_hours <= cfg_wdata[HOURS_W-1:0];
                REG_RUN_MINUTES:      cfg_reg.run_minutes <= cfg_wdata[MIN_W-1:0];
                REG_COVER_DEBOUNCE:   cfg_reg.cover_debounce_count <= cfg_wdata[DEB_W-1:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata[6:0];
        end
    end

    uvss_debounce u_debounce
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample           (active && in_data_reg[1]),
        .level            (in_data_reg[2]),
        .limit            (cfg_reg.cover_debounce_count),
        .cover_state_next (cover_next)
    );

    uvss_schedule u_schedule
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (tick_step),
        .enable         (in_data_reg[3]),
        .blk            (cover_block_reg || extract_block_reg),
        .cfg            (cfg_reg),
        .req            (req),
        .run_phase_next (run_phase_next)
    );

    always_comb
    begin
        cover_block_next   = cover_block_reg;
        extract_block_next = extract_block_reg;
        lamp_next          = lamp_reg;
        if (tick_step)
        begin
            cover_block_next = !cover_next;
            if (in_data_reg[4])
            begin
                extract_block_next = 1'b1;
            end
            else if (!in_data_reg[5])
            begin
                extract_block_next = 1'b0;
            end
            lamp_next = req && !(cover_block_next || extract_block_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cover_block_reg   <= 1'b0;
            extract_block_reg <= 1'b0;
            lamp_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            cover_block_reg   <= cover_block_next;
            extract_block_reg <= extract_block_next;
            lamp_reg          <= lamp_next;
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {cover_block_next || extract_block_next, cover_next,
                             run_phase_next, lamp_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

    // lamp never drives while a block is reported
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[3]))
    else $error("lamp on while blocked");

    // lamp only drives during the run phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> m_tdata[1])
    else $error("lamp on outside run phase");

    // input side stalls only when both stages are full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

    // a result follows every advanced item
    assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> m_tvalid)
    else $error("result lost after advance");

endmodule
